// File: rtl/bitmap_page_allocator_defines.svh
// Assertion macros shared by the bitmap page allocator RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// General property, checked on every rising clock edge outside reset
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bpa: property failed");
// Same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpa: implication failed");
`else
`define BPA_ASSERT(lbl, prop)
`define BPA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OOM  = 2'd1,
    STATUS_ZERO = 2'd2,
    STATUS_BAD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Control broadcast from the sequencer to the cell ring
  typedef struct packed {
    logic shift;     // rotate the ring by one slot
    logic set_run;   // mark the run that just passed the head as used
    logic clr_tail;  // clear the page leaving the head
  } ring_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_page_allocator.sv
// Bitmap first-fit page allocator, top level.
//
// Channels: request words (func_i, page_address_i, page_count_i) enter on
// in_valid_i / in_stall_o; result words (granted_address_o, status_o) leave
// on out_valid_o / out_stall_i. A word moves at a clock edge with valid high
// and stall low. The pool base register is written over cfg_valid_i /
// cfg_ready_o with cfg_pool_base_address_i. The user must write it only
// between requests; the block does not enforce it. Each request rotates
// the ring of page cells once, one page per cycle; its result word is
// loaded in S_DONE after the revolution, and a new request is taken only
// in S_IDLE. The first fit is found, and the run marked, in the same pass;
// a free is checked and its pages cleared as they pass the head.
// Reset marks every page free, sets the pool base to 0x0010_0000 and empties
// the result register. While the receiver stalls, the result word holds and
// the next request may run its scan; it then waits until the word is taken.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
  parameter int unsigned PAGE_COUNT = 64,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_pool_base_address_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] page_address_i,
  input  logic [6:0]  page_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o
);

  localparam logic [bpa_pkg::ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

  logic [bpa_pkg::ADDR_W-1:0]  base_q;
  bpa_pkg::ring_ctrl_t         ring_ctrl;
  logic [bpa_pkg::COUNT_W-1:0] ring_count;
  logic                        head;

  // Pool base register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_pool_base_address_i;
    end
  end

  bpa_ctrl #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .page_address_i    (page_address_i),
    .page_count_i      (page_count_i),
    .base_i            (base_q),
    .head_i            (head),
    .ring_ctrl_o       (ring_ctrl),
    .count_o           (ring_count),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o)
  );

  bpa_ring #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .count_i (ring_count),
    .head_o  (head)
  );

endmodule

`default_nettype wire

// File: rtl/bpa_cell.sv
// One slot of the page ring: holds a used bit and takes its neighbor's bit
// on a shift unless it marks a run or clears a freed page. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_cell #(
  parameter int unsigned PAGE_COUNT = 64,
  parameter int unsigned SLOT       = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpa_pkg::ring_ctrl_t             ctrl_i,
  input  logic [bpa_pkg::COUNT_W-1:0]     count_i,
  input  logic                            nbr_i,
  output logic                            used_o
);

  localparam int unsigned CMP_W   = $clog2(PAGE_COUNT + (1 << bpa_pkg::COUNT_W)) + 1;
  localparam bit          IS_TAIL = (SLOT == PAGE_COUNT - 1);

  logic in_run;
  logic used_d, used_q;

  // Slot lies within the last count slots behind the head
  assign in_run = (CMP_W'(SLOT) + CMP_W'(count_i)) >= CMP_W'(PAGE_COUNT);

  // Shift, mark a granted run, or clear a freed page
  always_comb begin
    used_d = used_q;
    if (ctrl_i.shift) begin
      if (ctrl_i.set_run && in_run) begin
        used_d = 1'b1;
      end else if (ctrl_i.clr_tail && IS_TAIL) begin
        used_d = 1'b0;
      end else begin
        used_d = nbr_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  assign used_o = used_q;

endmodule

`default_nettype wire

// File: rtl/bpa_ring.sv
// Ring of page cells; slot 0 is the head seen by the sequencer.
// Depends on bpa_pkg and bpa_cell.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ring #(
  parameter int unsigned PAGE_COUNT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpa_pkg::ring_ctrl_t         ctrl_i,
  input  logic [bpa_pkg::COUNT_W-1:0] count_i,
  output logic                        head_o
);

  logic [PAGE_COUNT-1:0] used;

  // Each slot takes the bit of the slot above it; the head wraps to the tail
  for (genvar j = 0; j < PAGE_COUNT; j++) begin : g_cell
    bpa_cell #(
      .PAGE_COUNT (PAGE_COUNT),
      .SLOT       (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .nbr_i   (used[(j + 1) % PAGE_COUNT]),
      .used_o  (used[j])
    );
  end

  assign head_o = used[0];

endmodule

`default_nettype wire

// File: rtl/bpa_ctrl.sv
// Request sequencer: runs one ring revolution per request, tracks free runs
// and the free target, and holds the result word. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_allocator_defines.svh"

module bpa_ctrl #(
  parameter int unsigned PAGE_COUNT = 64,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [bpa_pkg::ADDR_W-1:0]  page_address_i,
  input  logic [bpa_pkg::COUNT_W-1:0] page_count_i,
  input  logic [bpa_pkg::ADDR_W-1:0]  base_i,
  input  logic                        head_i,
  output bpa_pkg::ring_ctrl_t         ring_ctrl_o,
  output logic [bpa_pkg::COUNT_W-1:0] count_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bpa_pkg::ADDR_W-1:0]  granted_address_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned IDX_W = $clog2(PAGE_COUNT);
  localparam int unsigned CMP_W = $clog2(PAGE_COUNT + (1 << bpa_pkg::COUNT_W)) + 1;
  localparam logic [IDX_W-1:0]          LAST = IDX_W'(PAGE_COUNT - 1);
  localparam logic [bpa_pkg::ADDR_W-1:0] PB  = bpa_pkg::ADDR_W'(PAGE_BYTES);

  bpa_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0]            t_q;
  logic                        func_q;
  logic [bpa_pkg::COUNT_W-1:0] count_q;
  logic [bpa_pkg::ADDR_W-1:0]  off_q;
  logic                        below_q;
  logic [bpa_pkg::COUNT_W-1:0] run_q;
  logic [bpa_pkg::ADDR_W-1:0]  run_addr_q;
  logic [bpa_pkg::ADDR_W-1:0]  cur_addr_q;
  logic [bpa_pkg::ADDR_W-1:0]  offacc_q;
  logic [bpa_pkg::ADDR_W-1:0]  res_addr_q;
  logic                        found_q;
  logic                        ok_q;
  logic [bpa_pkg::COUNT_W-1:0] clr_left_q;
  logic                        out_valid_q;
  logic [bpa_pkg::ADDR_W-1:0]  out_addr_q;
  bpa_pkg::status_e            out_status_q;

  logic                        accept;
  logic                        load_out;
  logic [bpa_pkg::COUNT_W:0]   run_inc;
  logic                        hit;
  logic                        match;
  logic                        fits;
  logic                        start_clr;
  logic                        clr_head;
  logic                        scanning;
  bpa_pkg::status_e            res_status;
  logic [bpa_pkg::ADDR_W-1:0]  res_addr;

  assign scanning = (state_q == bpa_pkg::S_SCAN);
  assign accept   = in_valid_i && !in_stall_o;

  // Allocate: grow the free run at the head, hit on the first full run
  assign run_inc = {1'b0, run_q} + (bpa_pkg::COUNT_W + 1)'(1);
  assign hit = scanning && (func_q == bpa_pkg::FUNC_ALLOC) && !found_q &&
               (count_q != '0) && !head_i && (run_inc >= {1'b0, count_q});

  // Free: the head page is the target when the offsets line up
  assign match = scanning && (func_q == bpa_pkg::FUNC_FREE) && !below_q &&
                 (off_q == offacc_q);
  assign fits  = (CMP_W'(t_q) + CMP_W'(count_q)) <= CMP_W'(PAGE_COUNT);
  assign start_clr = match && fits && (count_q != '0);
  assign clr_head  = start_clr || (clr_left_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::S_IDLE: if (accept)       state_d = bpa_pkg::S_SCAN;
      bpa_pkg::S_SCAN: if (t_q == LAST)  state_d = bpa_pkg::S_DONE;
      bpa_pkg::S_DONE: if (load_out)     state_d = bpa_pkg::S_IDLE;
      default:                           state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o           = 1'b1;
    ring_ctrl_o.shift    = 1'b0;
    ring_ctrl_o.set_run  = 1'b0;
    ring_ctrl_o.clr_tail = 1'b0;
    load_out             = 1'b0;
    case (state_q)
      bpa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
      end
      bpa_pkg::S_SCAN: begin
        ring_ctrl_o.shift    = 1'b1;
        ring_ctrl_o.set_run  = hit;
        ring_ctrl_o.clr_tail = clr_head;
      end
      bpa_pkg::S_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Result word of the finished request
  always_comb begin
    res_addr = '0;
    if (func_q == bpa_pkg::FUNC_FREE) begin
      res_status = ok_q ? bpa_pkg::STATUS_OK : bpa_pkg::STATUS_BAD;
    end else if (count_q == '0) begin
      res_status = bpa_pkg::STATUS_ZERO;
    end else if (found_q) begin
      res_status = bpa_pkg::STATUS_OK;
      res_addr   = res_addr_q;
    end else begin
      res_status = bpa_pkg::STATUS_OOM;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::S_IDLE;
      t_q         <= '0;
      found_q     <= 1'b0;
      ok_q        <= 1'b0;
      clr_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        t_q        <= '0;
        found_q    <= 1'b0;
        ok_q       <= 1'b0;
        clr_left_q <= '0;
      end else if (scanning) begin
        t_q <= (t_q == LAST) ? '0 : t_q + IDX_W'(1);
        if (hit) begin
          found_q <= 1'b1;
        end
        if (match && fits) begin
          ok_q <= 1'b1;
        end
        if (start_clr) begin
          clr_left_q <= count_q - bpa_pkg::COUNT_W'(1);
        end else if (clr_left_q != '0) begin
          clr_left_q <= clr_left_q - bpa_pkg::COUNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and scan datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= func_i;
      count_q    <= page_count_i;
      off_q      <= page_address_i - base_i;
      below_q    <= page_address_i < base_i;
      run_q      <= '0;
      run_addr_q <= base_i;
      cur_addr_q <= base_i;
      offacc_q   <= '0;
    end else if (scanning) begin
      cur_addr_q <= cur_addr_q + PB;
      offacc_q   <= offacc_q + PB;
      if (head_i) begin
        run_q      <= '0;
        run_addr_q <= cur_addr_q + PB;
      end else begin
        run_q <= run_inc[bpa_pkg::COUNT_W] ? '1 : run_inc[bpa_pkg::COUNT_W-1:0];
      end
      if (hit) begin
        res_addr_q <= run_addr_q;
      end
    end
    if (load_out) begin
      out_addr_q   <= res_addr;
      out_status_q <= res_status;
    end
  end

  assign count_o           = count_q;
  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

  `BPA_ASSERT_IMP(a_single_run, found_q, !ring_ctrl_o.set_run)
  `BPA_ASSERT_IMP(a_clr_free_only, ring_ctrl_o.clr_tail, func_q == bpa_pkg::FUNC_FREE)
  `BPA_ASSERT(a_scan_end, (scanning && t_q == LAST) |=> (state_q == bpa_pkg::S_DONE && t_q == '0))
  `BPA_ASSERT_IMP(a_clr_in_scan, !scanning, clr_left_q == '0)
  `BPA_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == bpa_pkg::S_DONE))

endmodule

`default_nettype wire

// File: sim/tb_bitmap_page_allocator.sv
// Self-checking testbench for the bitmap first-fit page allocator.
// Depends on bpa_pkg and bitmap_page_allocator; a scoreboard class keeps its own
// page bitmap and pool base, and predicts each result word as a request is taken.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int unsigned PAGES          = 64;
  localparam int unsigned BYTES_PER_PAGE = 4096;
  localparam logic [31:0] RESET_BASE     = 32'h0010_0000;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;

  typedef struct {
    logic [31:0] granted;
    status_e     status;
  } result_word_t;

  typedef struct {
    int unsigned start;
    int unsigned pages;
  } page_run_t;

  // Bitmap predictor plus the queue of result words still owed by the block
  class alloc_scoreboard;
    bit [PAGES-1:0] used_pages = '0;
    bit [31:0]      pool_base  = RESET_BASE;
    result_word_t   expected_words[$];
    int unsigned    errors     = 0;

    function void set_base(bit [31:0] base);
      pool_base = base;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // Predict the word for one accepted request and update the bitmap
    function void note_request(input bit fn, input bit [31:0] addr, input bit [6:0] cnt,
                               output status_e st, output int unsigned start_page);
      result_word_t   w;
      bit [PAGES-1:0] run_mask;
      bit [31:0]      offset;
      int unsigned    s;
      int unsigned    first_page;
      bit             found;
      w.granted  = '0;
      w.status   = STATUS_OK;
      start_page = 0;
      if (fn == FUNC_ALLOC) begin
        if (cnt == 0) begin
          w.status = STATUS_ZERO;
        end else if (cnt > PAGES) begin
          w.status = STATUS_OOM;
        end else begin
          found = 1'b0;
          for (s = 0; s + cnt <= PAGES && !found; s++) begin
            run_mask = ({PAGES{1'b1}} >> (PAGES - cnt)) << s;
            if ((used_pages & run_mask) == '0) begin
              found      = 1'b1;
              used_pages = used_pages | run_mask;
              w.granted  = pool_base + s * BYTES_PER_PAGE;
              start_page = s;
            end
          end
          if (!found) w.status = STATUS_OOM;
        end
      end else begin
        offset     = addr - pool_base;
        first_page = offset / BYTES_PER_PAGE;
        if (addr < pool_base || (offset % BYTES_PER_PAGE) != 0 ||
            first_page >= PAGES || first_page + cnt > PAGES) begin
          w.status = STATUS_BAD;
        end else if (cnt != 0) begin
          run_mask   = ({PAGES{1'b1}} >> (PAGES - cnt)) << first_page;
          used_pages = used_pages & ~run_mask;
        end
      end
      st = w.status;
      expected_words.push_back(w);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one accepted result word with the oldest prediction
    task check_result(logic [31:0] granted, logic [1:0] status);
      result_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word: addr %h status %0d", granted, status));
        return;
      end
      w = expected_words.pop_front();
      if (granted !== w.granted)
        report($sformatf("granted_address %h, expected %h", granted, w.granted));
      if (status !== w.status)
        report($sformatf("status %0d, expected %0d", status, w.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni                  = 1'b0;
  logic        cfg_valid_i             = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_pool_base_address_i = '0;
  logic        in_valid_i              = 1'b0;
  logic        in_stall_o;
  logic        func_i                  = FUNC_ALLOC;
  logic [31:0] page_address_i          = '0;
  logic [6:0]  page_count_i            = '0;
  logic        out_valid_o;
  logic        out_stall_i             = 1'b0;
  logic [31:0] granted_address_o;
  logic [1:0]  status_o;

  alloc_scoreboard sb = new();
  page_run_t       live_runs[$];
  int unsigned     sender_idle_pct   = 0;
  int unsigned     receiver_idle_pct = 0;
  int unsigned     hold_requests     = 0;
  int unsigned     hold_served       = 0;
  int unsigned     hold_left         = 0;
  int unsigned     quiet_cycles      = 0;

  bitmap_page_allocator #(
    .PAGE_COUNT(PAGES),
    .PAGE_BYTES(BYTES_PER_PAGE)
  ) dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_pool_base_address_i(cfg_pool_base_address_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .func_i                 (func_i),
    .page_address_i         (page_address_i),
    .page_count_i           (page_count_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .granted_address_o      (granted_address_o),
    .status_o               (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Drive the result stall: long hold-offs on request, random idling otherwise
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      sb.check_result(granted_address_o, status_o);
  end

  // End the run when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_bitmap_page_allocator: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word, hold it until taken, then predict its result
  task send_request(input logic fn, input logic [31:0] addr, input logic [6:0] cnt,
                    output status_e st, output int unsigned start_page);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    page_address_i <= addr;
    page_count_i   <= cnt;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(fn, addr, cnt, st, start_page);
  endtask

  task send(input logic fn, input logic [31:0] addr, input logic [6:0] cnt);
    status_e     st;
    int unsigned start_page;
    send_request(fn, addr, cnt, st, start_page);
  endtask

  // Drop valid and wait until every predicted word has come back
  task drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task write_base(input logic [31:0] base);
    @(negedge clk_i);
    cfg_valid_i             <= 1'b1;
    cfg_pool_base_address_i <= base;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_base(base);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random request: mostly allocations and frees of live runs, some noise
  task random_request();
    status_e     st;
    int unsigned start_page;
    int unsigned sel;
    int unsigned idx;
    int unsigned variant;
    page_run_t   run;
    logic [6:0]  cnt;
    logic [31:0] addr;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send(1'($urandom_range(0, 1)), $urandom, 7'($urandom_range(0, 127)));
    end else if (live_runs.size() == 0 || sel < 54) begin
      variant = $urandom_range(0, 99);
      if (variant < 60)      cnt = 7'($urandom_range(1, 4));
      else if (variant < 85) cnt = 7'($urandom_range(5, 16));
      else if (variant < 93) cnt = 7'($urandom_range(17, 64));
      else if (variant < 96) cnt = 7'd0;
      else                   cnt = 7'($urandom_range(65, 127));
      send_request(FUNC_ALLOC, $urandom, cnt, st, start_page);
      if (st == STATUS_OK) begin
        run.start = start_page;
        run.pages = 32'(cnt);
        live_runs.push_back(run);
      end
    end else begin
      idx     = $urandom_range(0, live_runs.size() - 1);
      run     = live_runs[idx];
      addr    = sb.pool_base + run.start * BYTES_PER_PAGE;
      variant = $urandom_range(0, 99);
      if (variant < 75) begin
        send(FUNC_FREE, addr, 7'(run.pages));
        live_runs.delete(idx);
      end else if (variant < 85) begin
        send(FUNC_FREE, addr, 7'($urandom_range(0, run.pages)));
      end else if (variant < 92) begin
        send(FUNC_FREE, addr, 7'(PAGES - run.start + $urandom_range(1, 8)));
      end else begin
        send(FUNC_FREE, addr + $urandom_range(1, BYTES_PER_PAGE - 1), 7'(run.pages));
      end
    end
  endtask

  // Reconfigure while idle, then run a block of random requests
  task run_segment(input logic [31:0] base, input int unsigned items,
                   input int unsigned s_idle, input int unsigned r_idle,
                   input int hold_at, input int pause_at);
    drain();
    write_base(base);
    sender_idle_pct   = s_idle;
    receiver_idle_pct = r_idle;
    for (int i = 0; i < items; i++) begin
      if (i == hold_at) hold_requests++;
      if (i == pause_at) drain();
      random_request();
    end
  endtask

  initial begin
    sender_idle_pct   = 16;
    receiver_idle_pct = 46;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero count, oversize, full pool, bad frees, refree, gap fit
    send(FUNC_ALLOC, 32'h0, 7'd0);
    send(FUNC_ALLOC, 32'hFFFF_FFFF, 7'd1);
    send(FUNC_ALLOC, 32'h0, 7'd64);
    send(FUNC_ALLOC, 32'h0, 7'd65);
    send(FUNC_ALLOC, 32'h0, 7'd127);
    send(FUNC_FREE, RESET_BASE, 7'd1);
    send(FUNC_ALLOC, 32'h0, 7'd64);
    send(FUNC_ALLOC, 32'h0, 7'd1);
    send(FUNC_FREE, RESET_BASE + 63 * BYTES_PER_PAGE, 7'd1);
    send(FUNC_FREE, RESET_BASE + 63 * BYTES_PER_PAGE, 7'd2);
    send(FUNC_FREE, RESET_BASE - 1, 7'd1);
    send(FUNC_FREE, RESET_BASE + 1, 7'd1);
    send(FUNC_FREE, RESET_BASE + 64 * BYTES_PER_PAGE, 7'd0);
    send(FUNC_FREE, RESET_BASE + 5 * BYTES_PER_PAGE, 7'd0);
    send(FUNC_FREE, RESET_BASE, 7'd64);
    send(FUNC_FREE, RESET_BASE, 7'd64);
    send(FUNC_FREE, 32'hFFFF_FFFF, 7'd127);
    send(FUNC_ALLOC, 32'h0, 7'd3);
    send(FUNC_ALLOC, 32'h0, 7'd5);
    send(FUNC_FREE, RESET_BASE, 7'd3);
    send(FUNC_ALLOC, 32'h0, 7'd2);
    send(FUNC_FREE, RESET_BASE, 7'd64);

    // Directed: granted address wraps past the top of the address space
    drain();
    write_base(32'hFFFF_F000);
    send(FUNC_ALLOC, 32'h0, 7'd1);
    send(FUNC_ALLOC, 32'h0, 7'd1);
    send(FUNC_FREE, 32'h0, 7'd1);
    send(FUNC_FREE, 32'hFFFF_F000, 7'd64);

    // Random blocks across idling regimes and pool bases
    run_segment(32'h0, 330, 16, 46, 100, -1);
    run_segment($urandom, 330, 46, 16, -1, 150);
    run_segment(RESET_BASE, 280, 0, 0, -1, -1);
    run_segment(32'hFFFF_FFFF, 60, 0, 0, -1, -1);

    // Let any stray word show up before the verdict
    drain();
    repeat (PAGES + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_bitmap_page_allocator: PASS");
    end else begin
      $display("tb_bitmap_page_allocator: FAIL");
    end
    $finish;
  end

endmodule
